### src/rbi_pkg.sv
// Shared types, widths, constants and the sine table of the ray/box intersection unit.
`default_nettype none

package rbi_pkg;

  // Fraction bits of all position and distance values.
  localparam int FRAC_BITS = 8;

  // Position difference width (origin against box edge or center).
  localparam int POS_W  = ((18 + FRAC_BITS > 24) ? 18 + FRAC_BITS : 24) + 1;
  // Rotated origin width, one extra fraction bit.
  localparam int ROT_W  = POS_W + 4;
  // Slab bound width after kind selection.
  localparam int SLAB_W = POS_W + 5;
  // Slab numerator width, bound difference scaled by the direction format.
  localparam int NUM_W  = SLAB_W + 14;
  // Quotient magnitude bits, one divider stage each.
  localparam int QUO_W  = NUM_W - 1;
  // Signed direction width, rotated direction included.
  localparam int DEN_W  = 19;
  localparam int DMAG_W = DEN_W - 1;
  // Slab distance width with room for the unbounded marks.
  localparam int T_W    = NUM_W + 1;
  // Divider pipeline depth: operand stage, one stage per quotient bit, sign stage.
  localparam int DIV_LAT = QUO_W + 2;

  localparam int FIFO_DEPTH = 4;

  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

  localparam logic [1:0] KIND_AXIS     = 2'd0;
  localparam logic [1:0] KIND_ORIENTED = 2'd1;

  // Outcome of the front classification.
  typedef enum logic [1:0] {
    CLS_MISS,
    CLS_INSIDE,
    CLS_SLAB
  } cls_e;

  // One ray and box as accepted.
  typedef struct packed {
    logic [1:0]         box_kind;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic [15:0]        box_angle;
  } ray_t;

  // Tag that travels beside the dividers.
  typedef struct packed {
    cls_e cls;
    logic unb_x;
    logic unb_y;
  } slab_tag_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    slab_tag_t                tag;
    logic signed [NUM_W-1:0]  num_x0;
    logic signed [NUM_W-1:0]  num_x1;
    logic signed [NUM_W-1:0]  num_y0;
    logic signed [NUM_W-1:0]  num_y1;
    logic signed [DEN_W-1:0]  den_x;
    logic signed [DEN_W-1:0]  den_y;
  } slab_item_t;

  // Quarter wave of round(16384 * sin(k * pi / 128)).
  localparam logic signed [15:0] SINE_QUARTER [65] = '{
    16'sd0,     16'sd402,   16'sd804,   16'sd1205,  16'sd1606,  16'sd2006,
    16'sd2404,  16'sd2801,  16'sd3196,  16'sd3590,  16'sd3981,  16'sd4370,
    16'sd4756,  16'sd5139,  16'sd5520,  16'sd5897,  16'sd6270,  16'sd6639,
    16'sd7005,  16'sd7366,  16'sd7723,  16'sd8076,  16'sd8423,  16'sd8765,
    16'sd9102,  16'sd9434,  16'sd9760,  16'sd10080, 16'sd10394, 16'sd10702,
    16'sd11003, 16'sd11297, 16'sd11585, 16'sd11866, 16'sd12140, 16'sd12406,
    16'sd12665, 16'sd12916, 16'sd13160, 16'sd13395, 16'sd13623, 16'sd13842,
    16'sd14053, 16'sd14256, 16'sd14449, 16'sd14635, 16'sd14811, 16'sd14978,
    16'sd15137, 16'sd15286, 16'sd15426, 16'sd15557, 16'sd15679, 16'sd15791,
    16'sd15893, 16'sd15986, 16'sd16069, 16'sd16143, 16'sd16207, 16'sd16261,
    16'sd16305, 16'sd16340, 16'sd16364, 16'sd16379, 16'sd16384
  };

  // Full-wave sine in Q1.14 for a 256-step angle.
  function automatic logic signed [15:0] sine_at(input logic [7:0] idx);
    logic signed [15:0] v;
    if (idx[6]) begin
      v = SINE_QUARTER[7'd64 - {1'b0, idx[5:0]}];
    end else begin
      v = SINE_QUARTER[{1'b0, idx[5:0]}];
    end
    return idx[7] ? -v : v;
  endfunction

endpackage

`default_nettype wire

### src/rbi_front.sv
// Front pipeline: rotates oriented boxes into their frame and sets up the slab divisions.
`default_nettype none

module rbi_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rbi_pkg::ray_t      in_ray_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rbi_pkg::slab_item_t out_item_o
);

  localparam int FRAC_BITS = rbi_pkg::FRAC_BITS;
  localparam int POS_W  = rbi_pkg::POS_W;
  localparam int ROT_W  = rbi_pkg::ROT_W;
  localparam int SLAB_W = rbi_pkg::SLAB_W;
  localparam int NUM_W  = rbi_pkg::NUM_W;
  localparam int DEN_W  = rbi_pkg::DEN_W;
  localparam int PROD_W = POS_W + 16;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DPROD_W = 32;
  localparam int DSUM_W  = DPROD_W + 1;

  // Whole pipe moves when its last stage is empty or drains.
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign en          = !v5_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage 1: input register.
  rbi_pkg::ray_t r1_q, r2_q, r3_q, r4_q;

  // Stage 2: angle lookup and origin relative to the box center.
  logic [16:0]              ang_sum;
  logic [7:0]               idx2;
  logic signed [15:0]       sin2_d, cos2_d, sin2_q, cos2_q;
  logic signed [POS_W-1:0]  lx2_d, ly2_d, lx2_q, ly2_q;

  always_comb begin
    ang_sum = {1'b0, r1_q.box_angle} + 17'd128;
    idx2    = ang_sum[15:8];
    sin2_d  = rbi_pkg::sine_at(idx2);
    cos2_d  = rbi_pkg::sine_at(idx2 + 8'd64);
    lx2_d   = POS_W'(r1_q.origin_x) - (POS_W'(r1_q.box_x) <<< FRAC_BITS);
    ly2_d   = POS_W'(r1_q.origin_y) - (POS_W'(r1_q.box_y) <<< FRAC_BITS);
  end

  // Stage 3: rotation products.
  logic signed [PROD_W-1:0]  p_lxc_q, p_lys_q, p_lyc_q, p_lxs_q;
  logic signed [DPROD_W-1:0] p_dxc_q, p_dys_q, p_dyc_q, p_dxs_q;

  // Stage 4: rounded rotated origin and direction.
  logic signed [SUM_W-1:0]  sx4, sy4;
  logic signed [DSUM_W-1:0] rx4, ry4;
  logic signed [ROT_W-1:0]  tx4_d, ty4_d, tx4_q, ty4_q;
  logic signed [DEN_W-1:0]  rdx4_d, rdy4_d, rdx4_q, rdy4_q;

  always_comb begin
    sx4    = SUM_W'(p_lxc_q) + SUM_W'(p_lys_q) + SUM_W'(4096);
    sy4    = SUM_W'(p_lyc_q) - SUM_W'(p_lxs_q) + SUM_W'(4096);
    rx4    = DSUM_W'(p_dxc_q) + DSUM_W'(p_dys_q) + DSUM_W'(8192);
    ry4    = DSUM_W'(p_dyc_q) - DSUM_W'(p_dxs_q) + DSUM_W'(8192);
    tx4_d  = ROT_W'(sx4 >>> 13);
    ty4_d  = ROT_W'(sy4 >>> 13);
    rdx4_d = DEN_W'(rx4 >>> 14);
    rdy4_d = DEN_W'(ry4 >>> 14);
  end

  // Stage 5: slab bounds, zero-direction checks, numerators and the classification.
  logic signed [SLAB_W-1:0] ox5, oy5, lox5, hix5, loy5, hiy5, wx5, hy5;
  logic signed [SLAB_W-1:0] dlx5, dhx5, dly5, dhy5;
  logic signed [DEN_W-1:0]  dx5, dy5;
  logic                     zx5, zy5, outx5, outy5, blocked5;
  rbi_pkg::slab_item_t      item5_d, item5_q;

  always_comb begin
    wx5 = SLAB_W'($signed({1'b0, r4_q.box_width})) <<< FRAC_BITS;
    hy5 = SLAB_W'($signed({1'b0, r4_q.box_height})) <<< FRAC_BITS;
    if (r4_q.box_kind == rbi_pkg::KIND_AXIS) begin
      ox5  = SLAB_W'(r4_q.origin_x);
      oy5  = SLAB_W'(r4_q.origin_y);
      lox5 = SLAB_W'(r4_q.box_x) <<< FRAC_BITS;
      loy5 = SLAB_W'(r4_q.box_y) <<< FRAC_BITS;
      hix5 = lox5 + wx5;
      hiy5 = loy5 + hy5;
      dx5  = DEN_W'(r4_q.dir_x);
      dy5  = DEN_W'(r4_q.dir_y);
    end else begin
      ox5  = SLAB_W'(tx4_q);
      oy5  = SLAB_W'(ty4_q);
      lox5 = -wx5;
      hix5 = wx5;
      loy5 = -hy5;
      hiy5 = hy5;
      dx5  = rdx4_q;
      dy5  = rdy4_q;
    end
    zx5      = (dx5 == '0);
    zy5      = (dy5 == '0);
    outx5    = (ox5 < lox5) || (ox5 > hix5);
    outy5    = (oy5 < loy5) || (oy5 > hiy5);
    blocked5 = (zx5 && outx5) || (zy5 && outy5);
    dlx5     = lox5 - ox5;
    dhx5     = hix5 - ox5;
    dly5     = loy5 - oy5;
    dhy5     = hiy5 - oy5;

    item5_d.den_x     = dx5;
    item5_d.den_y     = dy5;
    item5_d.tag.unb_x = zx5;
    item5_d.tag.unb_y = zy5;
    // Axis-aligned numerators carry 14 bits of direction scale, rotated ones 13.
    if (r4_q.box_kind == rbi_pkg::KIND_AXIS) begin
      item5_d.num_x0 = NUM_W'(dlx5) <<< 14;
      item5_d.num_x1 = NUM_W'(dhx5) <<< 14;
      item5_d.num_y0 = NUM_W'(dly5) <<< 14;
      item5_d.num_y1 = NUM_W'(dhy5) <<< 14;
    end else begin
      item5_d.num_x0 = NUM_W'(dlx5) <<< 13;
      item5_d.num_x1 = NUM_W'(dhx5) <<< 13;
      item5_d.num_y0 = NUM_W'(dly5) <<< 13;
      item5_d.num_y1 = NUM_W'(dhy5) <<< 13;
    end

    case (r4_q.box_kind)
      rbi_pkg::KIND_AXIS: begin
        if (!outx5 && !outy5) begin
          item5_d.tag.cls = rbi_pkg::CLS_INSIDE;
        end else if (blocked5) begin
          item5_d.tag.cls = rbi_pkg::CLS_MISS;
        end else begin
          item5_d.tag.cls = rbi_pkg::CLS_SLAB;
        end
      end
      rbi_pkg::KIND_ORIENTED: begin
        item5_d.tag.cls = blocked5 ? rbi_pkg::CLS_MISS : rbi_pkg::CLS_SLAB;
      end
      default: begin
        item5_d.tag.cls = rbi_pkg::CLS_MISS;
      end
    endcase
  end

  // Payload registers of all stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q    <= in_ray_i;
      r2_q    <= r1_q;
      sin2_q  <= sin2_d;
      cos2_q  <= cos2_d;
      lx2_q   <= lx2_d;
      ly2_q   <= ly2_d;
      r3_q    <= r2_q;
      p_lxc_q <= PROD_W'(lx2_q) * PROD_W'(cos2_q);
      p_lys_q <= PROD_W'(ly2_q) * PROD_W'(sin2_q);
      p_lyc_q <= PROD_W'(ly2_q) * PROD_W'(cos2_q);
      p_lxs_q <= PROD_W'(lx2_q) * PROD_W'(sin2_q);
      p_dxc_q <= DPROD_W'(r2_q.dir_x) * DPROD_W'(cos2_q);
      p_dys_q <= DPROD_W'(r2_q.dir_y) * DPROD_W'(sin2_q);
      p_dyc_q <= DPROD_W'(r2_q.dir_y) * DPROD_W'(cos2_q);
      p_dxs_q <= DPROD_W'(r2_q.dir_x) * DPROD_W'(sin2_q);
      r4_q    <= r3_q;
      tx4_q   <= tx4_d;
      ty4_q   <= ty4_d;
      rdx4_q  <= rdx4_d;
      rdy4_q  <= rdy4_d;
      item5_q <= item5_d;
    end
  end

  assign out_item_o = item5_q;

endmodule

`default_nettype wire

### src/rbi_fifo.sv
// Short queue of classified items between the front and the back.
`default_nettype none

module rbi_fifo #(
  parameter int DEPTH = rbi_pkg::FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rbi_pkg::slab_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output rbi_pkg::slab_item_t item_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rbi_pkg::slab_item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### src/rbi_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
`default_nettype none

module rbi_div (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [rbi_pkg::NUM_W-1:0] num_i,
  input  logic signed [rbi_pkg::DEN_W-1:0] den_i,
  output logic signed [rbi_pkg::NUM_W-1:0] quo_o
);

  localparam int NUM_W  = rbi_pkg::NUM_W;
  localparam int DEN_W  = rbi_pkg::DEN_W;
  localparam int QUO_W  = rbi_pkg::QUO_W;
  localparam int DMAG_W = rbi_pkg::DMAG_W;

  logic [QUO_W-1:0]  aq_q  [QUO_W+1];
  logic [DMAG_W-1:0] rem_q [QUO_W+1];
  logic [DMAG_W-1:0] dm_q  [QUO_W+1];
  logic              neg_q [QUO_W+1];
  logic [QUO_W-1:0]  aq_d  [QUO_W+1];
  logic [DMAG_W-1:0] rem_d [QUO_W+1];
  logic signed [NUM_W-1:0] num_abs, quo_q;
  logic signed [DEN_W-1:0] den_abs;

  assign num_abs = num_i[NUM_W-1] ? -num_i : num_i;
  assign den_abs = den_i[DEN_W-1] ? -den_i : den_i;

  // Operand stage and restoring steps, each stage on its own registers.
  always_comb begin
    logic [DMAG_W:0] trial;
    logic [DMAG_W:0] diff;
    logic            fits;
    aq_d[0]  = num_abs[QUO_W-1:0];
    rem_d[0] = '0;
    for (int i = 1; i <= QUO_W; i++) begin
      trial    = {rem_q[i-1], aq_q[i-1][QUO_W-1]};
      diff     = trial - {1'b0, dm_q[i-1]};
      fits     = (trial >= {1'b0, dm_q[i-1]});
      rem_d[i] = fits ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
      aq_d[i]  = {aq_q[i-1][QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dm_q[0]  <= den_abs[DMAG_W-1:0];
      neg_q[0] <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      for (int i = 0; i <= QUO_W; i++) begin
        aq_q[i]  <= aq_d[i];
        rem_q[i] <= rem_d[i];
      end
      for (int i = 1; i <= QUO_W; i++) begin
        dm_q[i]  <= dm_q[i-1];
        neg_q[i] <= neg_q[i-1];
      end
      // Sign stage.
      quo_q <= neg_q[QUO_W] ? -$signed({1'b0, aq_q[QUO_W]}) : $signed({1'b0, aq_q[QUO_W]});
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

### src/rbi_back.sv
// Back pipeline: four slab divisions, interval merge and the result register.
`default_nettype none

module rbi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_empty_i,
  input  rbi_pkg::slab_item_t in_item_i,
  output logic                in_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_hit_o,
  output logic [23:0]         out_dist_o
);

  localparam int NUM_W   = rbi_pkg::NUM_W;
  localparam int T_W     = rbi_pkg::T_W;
  localparam int DIV_LAT = rbi_pkg::DIV_LAT;
  localparam logic signed [T_W-1:0] T_INF = {1'b0, {NUM_W{1'b1}}};

  logic en;
  logic vout_q, vy_q;
  logic v_q [DIV_LAT];
  rbi_pkg::slab_tag_t tag_q [DIV_LAT];

  assign en          = !vout_q || out_ready_i;
  assign in_pop_o    = en && !in_empty_i;
  assign out_valid_o = vout_q;

  // Valid bits along the divider stages, merge stage and output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        v_q[i] <= 1'b0;
      end
      vy_q   <= 1'b0;
      vout_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= !in_empty_i;
      for (int i = 1; i < DIV_LAT; i++) begin
        v_q[i] <= v_q[i-1];
      end
      vy_q   <= v_q[DIV_LAT-1];
      vout_q <= vy_q;
    end
  end

  // Tag travels beside the dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0] <= in_item_i.tag;
      for (int i = 1; i < DIV_LAT; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  logic signed [NUM_W-1:0] qx0, qx1, qy0, qy1;

  rbi_div u_div_x0 (.clk_i(clk_i), .en_i(en), .num_i(in_item_i.num_x0),
                    .den_i(in_item_i.den_x), .quo_o(qx0));
  rbi_div u_div_x1 (.clk_i(clk_i), .en_i(en), .num_i(in_item_i.num_x1),
                    .den_i(in_item_i.den_x), .quo_o(qx1));
  rbi_div u_div_y0 (.clk_i(clk_i), .en_i(en), .num_i(in_item_i.num_y0),
                    .den_i(in_item_i.den_y), .quo_o(qy0));
  rbi_div u_div_y1 (.clk_i(clk_i), .en_i(en), .num_i(in_item_i.num_y1),
                    .den_i(in_item_i.den_y), .quo_o(qy1));

  // Order each slab's entry and exit; a zero direction leaves the axis open.
  logic signed [T_W-1:0] ax0, ax1, ay0, ay1;
  logic signed [T_W-1:0] x0_d, x1_d, y0_d, y1_d, x0_q, x1_q, y0_q, y1_q;
  rbi_pkg::cls_e         cls_y_q;

  always_comb begin
    ax0 = T_W'(qx0);
    ax1 = T_W'(qx1);
    ay0 = T_W'(qy0);
    ay1 = T_W'(qy1);
    if (tag_q[DIV_LAT-1].unb_x) begin
      x0_d = -T_INF;
      x1_d = T_INF;
    end else begin
      x0_d = (ax0 > ax1) ? ax1 : ax0;
      x1_d = (ax0 > ax1) ? ax0 : ax1;
    end
    if (tag_q[DIV_LAT-1].unb_y) begin
      y0_d = -T_INF;
      y1_d = T_INF;
    end else begin
      y0_d = (ay0 > ay1) ? ay1 : ay0;
      y1_d = (ay0 > ay1) ? ay0 : ay1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q    <= x0_d;
      x1_q    <= x1_d;
      y0_q    <= y0_d;
      y1_q    <= y1_d;
      cls_y_q <= tag_q[DIV_LAT-1].cls;
    end
  end

  // Merge the two intervals and pick the first non-negative crossing.
  logic signed [T_W-1:0] lo_z, hi_z, t_z;
  logic                  hit_d, hit_q;
  logic [23:0]           dist_d, dist_q;

  always_comb begin
    lo_z   = (y0_q > x0_q) ? y0_q : x0_q;
    hi_z   = (y1_q < x1_q) ? y1_q : x1_q;
    t_z    = (lo_z >= 0) ? lo_z : hi_z;
    hit_d  = 1'b0;
    dist_d = '0;
    case (cls_y_q)
      rbi_pkg::CLS_INSIDE: begin
        hit_d = 1'b1;
      end
      rbi_pkg::CLS_SLAB: begin
        if (!((x0_q > y1_q) || (y0_q > x1_q)) && (hi_z >= 0)) begin
          hit_d  = 1'b1;
          dist_d = (t_z > $signed(T_W'(rbi_pkg::DIST_MAX))) ? rbi_pkg::DIST_MAX : t_z[23:0];
        end
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign out_hit_o  = hit_q;
  assign out_dist_o = dist_q;

endmodule

`default_nettype wire

### src/ray_box_intersect_2d_unit.sv
// Top level of the 2D ray against axis-aligned or oriented box intersection unit.
//
// Channel  Dir  tdata                                              tuser
// s_axis   in   origin_x, origin_y, dir_x, dir_y, box_x, box_y,    box_kind
//               box_width, box_height, box_angle (160 bits)
// m_axis   out  hit_distance (24 bits)                             hit
//
// One ray is accepted per cycle and one result leaves per cycle while m_axis_tready stays high.
// The path holds 5 + 1 + (rbi_pkg::QUO_W + 2) + 2 = 55 register stages at 8 fraction bits,
// most of them in the bit-per-stage slab dividers.
// Reset clears all valid flags and the queue; nothing else needs clearing.
// A stalled output freezes the back; the front keeps accepting until the queue fills.
`default_nettype none

module ray_box_intersect_2d_unit #(
  parameter int FIFO_DEPTH = rbi_pkg::FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [23:0] origin_x, [47:24] origin_y, [63:48] dir_x, [79:64] dir_y,
  // [95:80] box_x, [111:96] box_y, [127:112] box_width, [143:128] box_height,
  // [159:144] box_angle
  input  logic [159:0] s_axis_tdata,
  // [1:0] box_kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [23:0] hit_distance
  output logic [23:0]  m_axis_tdata,
  // [0] hit
  output logic         m_axis_tuser
);

  rbi_pkg::ray_t       ray;
  rbi_pkg::slab_item_t front_item, queue_item;
  logic front_valid, queue_full, queue_empty, queue_push, queue_pop;

  // Unpack the input transaction.
  always_comb begin
    ray.box_kind   = s_axis_tuser;
    ray.origin_x   = s_axis_tdata[23:0];
    ray.origin_y   = s_axis_tdata[47:24];
    ray.dir_x      = s_axis_tdata[63:48];
    ray.dir_y      = s_axis_tdata[79:64];
    ray.box_x      = s_axis_tdata[95:80];
    ray.box_y      = s_axis_tdata[111:96];
    ray.box_width  = s_axis_tdata[127:112];
    ray.box_height = s_axis_tdata[143:128];
    ray.box_angle  = s_axis_tdata[159:144];
  end

  rbi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_ray_i    (ray),
    .out_valid_o (front_valid),
    .out_ready_i (!queue_full),
    .out_item_o  (front_item)
  );

  assign queue_push = front_valid && !queue_full;

  rbi_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .item_o  (queue_item)
  );

  rbi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_empty_i  (queue_empty),
    .in_item_i   (queue_item),
    .in_pop_o    (queue_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (m_axis_tuser),
    .out_dist_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### src/rbi_checker.sv
// Port-level checks on the intersection unit, bound to its top level.
`default_nettype none

module rbi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A miss always reports distance zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd0)
    else $error("miss with nonzero distance");

  // No result is offered right out of reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result offered at reset release");

endmodule

bind ray_box_intersect_2d_unit rbi_checker u_rbi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/ray_box_intersect_2d_unit_test.sv
// Self-checking testbench of the 2D ray against box intersection unit.
`timescale 1ns / 100ps
`default_nettype none

module ray_box_intersect_2d_unit_test;

  localparam int LATENCY = 80;
  localparam int RANDOM_RAYS = 500;
  localparam logic [1:0] KIND_BAD2 = 2'd2;
  localparam logic [1:0] KIND_BAD3 = 2'd3;
  localparam longint T_UNB = 64'sh4000000000000000;
  localparam longint DMAX = 64'hFFFFFF;

  typedef struct packed {
    logic        hit;
    logic [23:0] hit_distance;
  } hit_t;

  // One row of the directed table; chk says a typed-in answer is given.
  typedef struct {
    rbi_pkg::ray_t ray;
    logic          chk;
    hit_t          res;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tuser;

  hit_t expected_hits[$];
  int   fail_count;
  int   hits_seen;
  int   results_seen;
  bit   quiet_phase;
  bit   hold_off_done;

  ray_box_intersect_2d_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Full-wave sine from the quarter table, written out independently.
  function automatic longint wave_sine(input int idx);
    int q;
    int r;
    longint v;
    q = (idx >> 6) & 3;
    r = idx & 63;
    v = (q & 1) ? rbi_pkg::SINE_QUARTER[64 - r] : rbi_pkg::SINE_QUARTER[r];
    return (q & 2) ? -v : v;
  endfunction

  // Round half-up with floor semantics.
  function automatic longint round_half_up(input longint v, input int s);
    longint x;
    x = v + (64'sd1 <<< (s - 1));
    return x >>> s;
  endfunction

  // Slab interval along one axis; returns 0 when a still axis misses.
  function automatic bit slab_span(input longint o, input longint lo, input longint hi,
                                   input longint d, input longint k,
                                   output longint t0, output longint t1);
    longint a;
    longint b;
    if (d == 0) begin
      t0 = -T_UNB;
      t1 = T_UNB;
      return (o >= lo && o <= hi);
    end
    a = ((lo - o) * k) / d;
    b = ((hi - o) * k) / d;
    t0 = (a > b) ? b : a;
    t1 = (a > b) ? a : b;
    return 1'b1;
  endfunction

  // Expected hit and distance of one ray against one box.
  function automatic hit_t predict_hit(input rbi_pkg::ray_t r);
    longint ox, oy, dx, dy, bx, by, w, h;
    longint x0, x1, y0, y1, lo, hi, t, s, c, lx, ly, tx, ty, rdx, rdy;
    bit ok;
    hit_t res;
    ox = r.origin_x; oy = r.origin_y; dx = r.dir_x; dy = r.dir_y;
    bx = r.box_x; by = r.box_y; w = r.box_width; h = r.box_height;
    res = '0;
    ok = 1'b0;
    if (r.box_kind == rbi_pkg::KIND_AXIS) begin
      if (ox >= bx * 256 && ox <= (bx + w) * 256 && oy >= by * 256 && oy <= (by + h) * 256) begin
        res.hit = 1'b1;
        return res;
      end
      ok = slab_span(ox, bx * 256, (bx + w) * 256, dx, 16384, x0, x1);
      if (ok) ok = slab_span(oy, by * 256, (by + h) * 256, dy, 16384, y0, y1);
    end else if (r.box_kind == rbi_pkg::KIND_ORIENTED) begin
      s = wave_sine(((int'(r.box_angle) + 128) >> 8) & 255);
      c = wave_sine((((int'(r.box_angle) + 128) >> 8) & 255) + 64);
      lx = ox - bx * 256;
      ly = oy - by * 256;
      tx = round_half_up(lx * c + ly * s, 13);
      ty = round_half_up(ly * c - lx * s, 13);
      rdx = round_half_up(dx * c + dy * s, 14);
      rdy = round_half_up(dy * c - dx * s, 14);
      ok = slab_span(tx, -w * 256, w * 256, rdx, 8192, x0, x1);
      if (ok) ok = slab_span(ty, -h * 256, h * 256, rdy, 8192, y0, y1);
    end
    if (!ok || x0 > y1 || y0 > x1) return res;
    lo = (y0 > x0) ? y0 : x0;
    hi = (y1 < x1) ? y1 : x1;
    if (hi < 0) return res;
    t = (lo >= 0) ? lo : hi;
    res.hit = 1'b1;
    res.hit_distance = (t > DMAX) ? 24'hFFFFFF : t[23:0];
    return res;
  endfunction

  function automatic rbi_pkg::ray_t make_ray(input logic [1:0] k, input int ox, input int oy,
                                             input int dx, input int dy, input int bx,
                                             input int by, input int w, input int h,
                                             input int a);
    rbi_pkg::ray_t r;
    r.box_kind = k; r.origin_x = 24'(ox); r.origin_y = 24'(oy);
    r.dir_x = 16'(dx); r.dir_y = 16'(dy);
    r.box_x = 16'(bx); r.box_y = 16'(by); r.box_width = 16'(w); r.box_height = 16'(h);
    r.box_angle = 16'(a);
    return r;
  endfunction

  // Random ray, mostly near a modest box so that hits are common.
  function automatic rbi_pkg::ray_t random_ray();
    rbi_pkg::ray_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom)};
    r.box_kind = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
    if ($urandom_range(0, 4) != 0) begin
      r.box_x = $signed(16'($urandom_range(0, 200))) - 16'sd100;
      r.box_y = $signed(16'($urandom_range(0, 200))) - 16'sd100;
      r.box_width = 16'($urandom_range(0, 60));
      r.box_height = 16'($urandom_range(0, 60));
      r.origin_x = ($signed(24'($urandom_range(0, 600))) - 24'sd300) * 24'sd256
                   + 24'($urandom_range(0, 255));
      r.origin_y = ($signed(24'($urandom_range(0, 600))) - 24'sd300) * 24'sd256
                   + 24'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
        0: r.dir_x = 16'sd0;
        1: r.dir_y = 16'sd0;
        2: r.dir_x = $signed(16'($urandom_range(0, 8))) - 16'sd4;
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) r.box_angle = 16'($urandom_range(0, 8)) << 13;
    end
    return r;
  endfunction

  // Offer one ray and wait until the block takes it.
  task automatic send_ray(input rbi_pkg::ray_t r);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.box_angle, r.box_height, r.box_width, r.box_y, r.box_x,
                      r.dir_y, r.dir_x, r.origin_y, r.origin_x};
    s_axis_tuser  <= r.box_kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stimulus: directed table, then random rays.
  initial begin
    row_t table_rows[$];
    rbi_pkg::ray_t r;
    hit_t p;
    int wait_cycles;
    fail_count = 0;
    quiet_phase = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    table_rows.push_back('{make_ray(rbi_pkg::KIND_AXIS, 5 * 256, 5 * 256, 16384, 0, 0, 0,
                                    10, 10, 0), 1'b1, '{1'b1, 24'd0}});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_AXIS, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                           1'b1, '{1'b1, 24'd0}});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_AXIS, -256, 0, 16384, 0, 0, 0, 10, 10, 0),
                           1'b1, '{1'b1, 24'd256}});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_AXIS, -256, 0, -16384, 0, 0, 0, 10, 10, 0),
                           1'b1, '{1'b0, 24'd0}});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_AXIS, -256, 20 * 256, 16384, 0, 0, 0,
                                    10, 10, 0), 1'b1, '{1'b0, 24'd0}});
    table_rows.push_back('{make_ray(KIND_BAD2, 0, 0, 16384, 0, 0, 0, 10, 10, 0),
                           1'b1, '{1'b0, 24'd0}});
    table_rows.push_back('{make_ray(KIND_BAD3, -1, -1, -1, -1, -1, -1, 65535, 65535, 65535),
                           1'b1, '{1'b0, 24'd0}});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_ORIENTED, 0, 0, 0, 0, 0, 0, 4, 4, 0),
                           1'b1, '{1'b1, 24'hFFFFFF}});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_AXIS, -8388608, -8388608, 1, 1, 32767, 32767,
                                    65535, 65535, 0), 1'b0, '0});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_AXIS, 8388607, 8388607, -32768, -32768,
                                    -32768, -32768, 65535, 65535, 0), 1'b0, '0});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_AXIS, -8388608, 0, 32767, 0, 32767, -5,
                                    0, 10, 0), 1'b0, '0});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_ORIENTED, 8388607, -8388608, 32767, -32768,
                                    -32768, 32767, 65535, 65535, 65535), 1'b0, '0});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_ORIENTED, -2560, 0, 16384, 0, 0, 0,
                                    3, 3, 8192), 1'b0, '0});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_ORIENTED, 0, 0, 1, 1, 0, 0, 3, 3, 127),
                           1'b0, '0});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_ORIENTED, 1000, 500, -700, 300, 1, 2,
                                    0, 0, 16384), 1'b0, '0});
    table_rows.push_back('{make_ray(rbi_pkg::KIND_ORIENTED, -3000, 2000, 11585, -11585, 0, 0,
                                    8, 2, 40000), 1'b0, '0});

    foreach (table_rows[i]) begin
      p = predict_hit(table_rows[i].ray);
      expected_hits.push_back(table_rows[i].chk ? table_rows[i].res : p);
      send_ray(table_rows[i].ray);
    end

    for (int n = 0; n < RANDOM_RAYS; n++) begin
      if (n == RANDOM_RAYS - 60) quiet_phase = 1'b1;
      r = random_ray();
      expected_hits.push_back(predict_hit(r));
      send_ray(r);
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while ((expected_hits.size() != 0 || wait_cycles < LATENCY) && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles = (expected_hits.size() == 0) ? wait_cycles + 1 : 0;
    end
    $display("Sent %0d rays (axis-aligned, oriented, unknown kinds); %0d results, %0d hits.",
             table_rows.size() + RANDOM_RAYS, results_seen, hits_seen);
    if (fail_count == 0 && expected_hits.size() == 0) begin
      $display("ray_box_intersect_2d_unit regression: pass");
    end else begin
      $display("ray_box_intersect_2d_unit regression: fail");
    end
    $finish;
  end

  // Receiver readiness: random stalls, one long hold-off, none at the end.
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    hold_off_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_off_done && results_seen >= 100) begin
        hold_off_done = 1'b1;
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 150; hold++) @(posedge clk_i);
      end
      m_axis_tready <= quiet_phase ? 1'b1 : ($urandom_range(0, 4) != 0);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen = results_seen + 1;
      if (m_axis_tuser) hits_seen = hits_seen + 1;
      if (expected_hits.size() == 0) begin
        $error("result with no expectation: hit %0d distance %0h", m_axis_tuser, m_axis_tdata);
        fail_count = fail_count + 1;
      end else begin
        want = expected_hits.pop_front();
        if (want.hit !== m_axis_tuser) begin
          $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser);
          fail_count = fail_count + 1;
        end
        if (want.hit_distance !== m_axis_tdata) begin
          $error("hit_distance: expected %0h, got %0h", want.hit_distance, m_axis_tdata);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  initial begin
    results_seen = 0;
    hits_seen = 0;
  end

  // Overall time limit.
  initial begin
    #400000;
    $display("ray_box_intersect_2d_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
